[src/smc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants for the sliding match counter
// Field widths, operation codes, register indexes and the cell control beat.
// ----------------------------------------------------------------------------
package smc_pkg;

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int PIDX_W   = 6;
  localparam int SYM_W    = 8;
  localparam int ALIGN_W  = 16;
  localparam int MCOUNT_W = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;
  localparam int PLEN_W   = 7;
  localparam int RCNT_W   = 17;

  // Operation codes carried in func
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_COUNT   = 4'd1;

  // Broadcast control to every cell of the row
  typedef struct packed {
    logic push;   // shift counts one cell down the row
    logic start;  // new text: drop all running alignments
    logic wr;     // pattern symbol write
  } cell_ctl_t;

endpackage

[src/smc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_in_if: input item channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface smc_in_if;
  logic                        valid;
  logic                        ready;
  logic [smc_pkg::FUNC_W-1:0]  func;
  logic [smc_pkg::PIDX_W-1:0]  pattern_index;
  logic [smc_pkg::SYM_W-1:0]   symbol;

  modport source (output valid, func, pattern_index, symbol, input ready);
  modport sink   (input valid, func, pattern_index, symbol, output ready);
endinterface

[src/smc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_out_if: result channel
// Valid/ready channel carrying one alignment count per beat.
// ----------------------------------------------------------------------------
interface smc_out_if;
  logic                          valid;
  logic                          ready;
  logic [smc_pkg::ALIGN_W-1:0]   alignment;
  logic [smc_pkg::MCOUNT_W-1:0]  match_count;
  logic                          last;

  modport source (output valid, alignment, match_count, last, input ready);
  modport sink   (input valid, alignment, match_count, last, output ready);
endinterface

[src/smc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface smc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [smc_pkg::CFG_IDX_W-1:0]   index;
  logic [smc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/smc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_cell: one pattern position of the match row
// Holds pattern symbol IDX and the running count of the alignment that has
// reached this position; on each text beat it takes its left neighbor's
// alignment, adds its own compare and passes it on.
// ----------------------------------------------------------------------------
module smc_cell #(
  parameter int IDX = 0,
  parameter int LW  = 7,
  parameter int NW  = 17,
  parameter int AW  = 16,
  parameter int CW  = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smc_pkg::cell_ctl_t         ctl,
  input  logic [smc_pkg::PIDX_W-1:0] wr_idx,
  input  logic [smc_pkg::SYM_W-1:0]  sym,
  input  logic [LW-1:0]              len_eff,
  input  logic [NW-1:0]              nres_eff,
  input  logic                       prev_valid,
  input  logic [AW-1:0]              prev_align,
  input  logic [CW-1:0]              prev_cnt,
  output logic                       valid,
  output logic [AW-1:0]              align,
  output logic [CW-1:0]              cnt
);
  import smc_pkg::*;

  logic          valid_r;
  logic [AW-1:0] align_r;
  logic [CW-1:0] cnt_r;
  logic [SYM_W-1:0] pat_r;
  logic          hit;
  logic          sel_wr;

  // Compare for the alignment entering this cell
  assign hit = prev_valid && (len_eff > LW'(IDX)) &&
               (NW'(prev_align) < nres_eff) && (pat_r == sym);

  assign sel_wr = ctl.wr && (int'(wr_idx) == IDX);

  // Alignment occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.start) begin
      valid_r <= 1'b0;
    end else if (ctl.push) begin
      valid_r <= prev_valid;
    end
  end

  // Running count and alignment number move down the row
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      align_r <= prev_align;
      cnt_r   <= prev_cnt + CW'(hit);
    end
  end

  // Pattern symbol, undefined until written
  always_ff @(posedge clk) begin
    if (sel_wr) begin
      pat_r <= sym;
    end
  end

  assign valid = valid_r;
  assign align = align_r;
  assign cnt   = cnt_r;

  // A live alignment has seen at most IDX+1 compares
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (int'(cnt_r) <= IDX + 1))
    else $error("cell count exceeds its position");

endmodule

[src/sliding_match_count.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_match_count: sliding-window symbol match counter
// Counts, for every alignment of a loaded pattern over a text stream, the
// positions where text and pattern bytes agree (Hamming distance kernel).
// ----------------------------------------------------------------------------
//  port    | dir | beat contents
//  --------+-----+-----------------------------------------------
//  in_if   | in  | func, pattern_index, symbol
//  out_if  | out | alignment, match_count, last
//  cfg_if  | in  | index (0 pattern_length, 1 result_count), data
//
//  A text push first updates the cell row; the count at position
//  pattern_length-1 is then picked into the output register.
//  Pattern writes, start and unused codes leave no select pending.
//  A finished result waiting in the output register does not block input;
//  after a push, input stalls until the pick, which waits for that register to free.
//  Reset (synchronous, rst_n low) clears text position, cell occupancy and
//  sets pattern_length and result_count to 1; pattern symbols stay unknown.
// ----------------------------------------------------------------------------
module sliding_match_count #(
  parameter int MAX_PATTERN = 64,
  parameter int MAX_TEXT    = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  smc_in_if.sink     in_if,
  smc_out_if.source  out_if,
  smc_cfg_if.sink    cfg_if
);
  import smc_pkg::*;

  localparam int PCL = $clog2(MAX_PATTERN + 1);
  localparam int LW  = (PCL > PLEN_W) ? PCL : PLEN_W;
  localparam int TCL = $clog2(MAX_TEXT + 1);
  localparam int NW  = (TCL > RCNT_W) ? TCL : RCNT_W;
  localparam int TW  = TCL;
  localparam int AW  = $clog2(MAX_TEXT);
  localparam int CW  = PCL;
  localparam int PW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Configuration registers
  logic [PLEN_W-1:0] plen_r;
  logic [RCNT_W-1:0] rcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= PLEN_W'(1);
      rcnt_r <= RCNT_W'(1);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_PATTERN_LENGTH: plen_r <= cfg_if.data[PLEN_W-1:0];
        REG_RESULT_COUNT:   rcnt_r <= cfg_if.data[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  // Effective length and result count after clamping
  logic [LW-1:0] len_ext;
  logic [LW-1:0] len_eff;
  logic [NW-1:0] rcnt_ext;
  logic [NW-1:0] nres_eff;

  assign len_ext  = LW'(plen_r);
  assign len_eff  = (plen_r == '0) ? LW'(1) :
                    (len_ext > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : len_ext;
  assign rcnt_ext = NW'(rcnt_r);
  assign nres_eff = (rcnt_ext > NW'(MAX_TEXT)) ? NW'(MAX_TEXT) : rcnt_ext;

  // Input decode
  logic      pend_r;
  logic      in_acc;
  logic      push_ok;
  cell_ctl_t ctl;
  logic [TW-1:0] tpos_r;

  assign in_if.ready = !pend_r;
  assign in_acc      = in_if.valid && in_if.ready;
  assign push_ok     = tpos_r < TW'(MAX_TEXT);

  always_comb begin
    ctl = '0;
    if (in_acc) begin
      case (in_if.func)
        FUNC_WRITE: ctl.wr    = 1'b1;
        FUNC_PUSH:  ctl.push  = push_ok;
        FUNC_START: ctl.start = 1'b1;
        default: ;
      endcase
    end
  end

  // Text position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpos_r <= '0;
    end else if (ctl.start) begin
      tpos_r <= '0;
    end else if (ctl.push) begin
      tpos_r <= tpos_r + TW'(1);
    end
  end

  // Row of cells; cell 0 is fed a fresh alignment starting at tpos_r
  logic          c_valid [MAX_PATTERN];
  logic [AW-1:0] c_align [MAX_PATTERN];
  logic [CW-1:0] c_cnt   [MAX_PATTERN];

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic          p_valid;
    logic [AW-1:0] p_align;
    logic [CW-1:0] p_cnt;

    if (k == 0) begin : g_head
      assign p_valid = 1'b1;
      assign p_align = AW'(tpos_r);
      assign p_cnt   = '0;
    end else begin : g_link
      assign p_valid = c_valid[k-1];
      assign p_align = c_align[k-1];
      assign p_cnt   = c_cnt[k-1];
    end

    smc_cell #(
      .IDX (k),
      .LW  (LW),
      .NW  (NW),
      .AW  (AW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .wr_idx     (in_if.pattern_index),
      .sym        (in_if.symbol),
      .len_eff    (len_eff),
      .nres_eff   (nres_eff),
      .prev_valid (p_valid),
      .prev_align (p_align),
      .prev_cnt   (p_cnt),
      .valid      (c_valid[k]),
      .align      (c_align[k]),
      .cnt        (c_cnt[k])
    );
  end

  // Pick the alignment that just completed its window
  logic [PW-1:0] sel;
  logic          s_valid;
  logic [AW-1:0] s_align;
  logic [CW-1:0] s_cnt;
  logic          emit;
  logic          is_last;
  logic          out_free;

  assign sel     = PW'(len_eff - LW'(1));
  assign s_valid = c_valid[sel];
  assign s_align = c_align[sel];
  assign s_cnt   = c_cnt[sel];
  assign emit    = s_valid && (NW'(s_align) < nres_eff);
  assign is_last = NW'(s_align) == (nres_eff - NW'(1));
  assign out_free = !out_if.valid || out_if.ready;

  // Pending select after a push
  logic pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (pend_r && out_free) begin
      pend_nxt = 1'b0;
    end else if (ctl.push) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [ALIGN_W-1:0]  out_align_r;
  logic [MCOUNT_W-1:0] out_cnt_r;
  logic                out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pend_r && out_free) begin
      out_valid_nxt = emit;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && out_free) begin
      out_align_r <= ALIGN_W'(s_align);
      out_cnt_r   <= MCOUNT_W'(s_cnt);
      out_last_r  <= is_last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.alignment   = out_align_r;
  assign out_if.match_count = out_cnt_r;
  assign out_if.last        = out_last_r;

  // A new result only ever follows a pending select
  a_rise_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result appeared without a pending push");

  // Every text beat that moves the row leaves a select pending
  a_push_pend: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> pend_r)
    else $error("push did not schedule a select");

  // Text position advances only on a row shift
  a_tpos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!ctl.push && !ctl.start) |=> $stable(tpos_r))
    else $error("text position moved without a push or start");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for sliding_match_count
// Loads the pattern store, then streams text through the block under several
// register settings with random idles on the input and the result channel.
// A scoreboard keeps its own copy of the pattern store and the per-alignment
// running counts and checks every result beat in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import smc_pkg::*;

  localparam int     PAT_DEPTH    = 64;
  localparam int     TEXT_DEPTH   = 65536;
  localparam int     RANDOM_ITEMS = 1540;
  localparam int     LONG_PUSHES  = 100;
  localparam int     CFG_SETTLE   = 4;   // lets the push path settle
  localparam int     TAIL_CYCLES  = 16;
  localparam int     REPORT_CAP   = 30;
  localparam longint CYCLE_LIMIT  = 3_000_000;

  // func code the block does not use
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [ALIGN_W-1:0]  alignment;
    logic [MCOUNT_W-1:0] match_count;
    logic                last;
  } count_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors pattern store, running counts and registers
  // --------------------------------------------------------------------------
  class match_count_tracker;
    logic [SYM_W-1:0]    pattern [PAT_DEPTH];
    logic [MCOUNT_W-1:0] running [PAT_DEPTH];
    int unsigned         text_pos;
    logic [PLEN_W-1:0]   plen_reg;
    logic [RCNT_W-1:0]   rcnt_reg;
    count_beat_t         expected_counts [$];
    int unsigned         mismatches;

    function new();
      foreach (pattern[k]) pattern[k] = '0;
      foreach (running[k]) running[k] = '0;
      text_pos   = 0;
      plen_reg   = PLEN_W'(1);
      rcnt_reg   = RCNT_W'(1);
      mismatches = 0;
    endfunction

    // pattern_length 0 acts as 1, anything above the row acts as the row
    function int unsigned window_len();
      if (plen_reg == 0) return 1;
      if (plen_reg > PAT_DEPTH) return PAT_DEPTH;
      return 32'(plen_reg);
    endfunction

    function int unsigned result_limit();
      if (rcnt_reg > TEXT_DEPTH) return TEXT_DEPTH;
      return 32'(rcnt_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_PATTERN_LENGTH) plen_reg = data[PLEN_W-1:0];
      else if (idx == REG_RESULT_COUNT) rcnt_reg = data[RCNT_W-1:0];
    endfunction

    // returns 1 when the beat did real work (not an ignored one)
    function bit note_item(logic [FUNC_W-1:0] func, logic [PIDX_W-1:0] pidx,
                           logic [SYM_W-1:0] sym);
      int unsigned len;
      int unsigned nres;
      int unsigned a;
      int unsigned j;
      count_beat_t beat;
      bit          worked;
      worked = 1'b0;
      case (func)
        FUNC_WRITE: begin
          pattern[pidx] = sym;
          worked = 1'b1;
        end
        FUNC_START: begin
          foreach (running[k]) running[k] = '0;
          text_pos = 0;
          worked = 1'b1;
        end
        FUNC_PUSH: begin
          // pushes past the end of the text space are dropped
          if (text_pos < TEXT_DEPTH) begin
            len  = window_len();
            nres = result_limit();
            // a new alignment opens at the current position
            running[text_pos % PAT_DEPTH] = '0;
            for (j = 0; j < len && j <= text_pos; j++) begin
              a = text_pos - j;
              if (a < nres && pattern[j] == sym)
                running[a % PAT_DEPTH] = running[a % PAT_DEPTH] + MCOUNT_W'(1);
            end
            // the alignment whose last byte this was is complete
            if (text_pos + 1 >= len) begin
              a = text_pos + 1 - len;
              if (a < nres) begin
                beat.alignment   = a[ALIGN_W-1:0];
                beat.match_count = running[a % PAT_DEPTH];
                beat.last        = (a == nres - 1);
                expected_counts  = {expected_counts, beat};
              end
            end
            text_pos++;
            worked = 1'b1;
          end
        end
        default: ;
      endcase
      return worked;
    endfunction

    function void flag(string field, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
    endfunction

    function void check_result(logic [ALIGN_W-1:0] alignment,
                               logic [MCOUNT_W-1:0] match_count, logic last);
      count_beat_t want;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("result beat for alignment %0d with no count pending", alignment);
        return;
      end
      want = expected_counts.pop_front();
      if (alignment !== want.alignment)
        flag("alignment", 32'(want.alignment), 32'(alignment));
      if (match_count !== want.match_count)
        flag("match_count", 32'(want.match_count), 32'(match_count));
      if (last !== want.last) flag("last", 32'(want.last), 32'(last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic   clk = 1'b0;
  logic   rst_n;
  longint cycles = 0;
  int     sink_mode = 0;       // 0 always ready, 1 light stalls, 2 heavy stalls
  int unsigned items_done = 0;

  match_count_tracker tracker = new();

  smc_in_if  cmd_if ();
  smc_out_if res_if ();
  smc_cfg_if reg_if ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_match_count u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_if),
    .out_if (res_if),
    .cfg_if (reg_if)
  );

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sliding_match_count regression: fail");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_result(res_if.alignment, res_if.match_count, res_if.last);
  end

  // Result sink with random back-pressure
  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((sink_mode == 1 && $urandom_range(0, 7) == 0) ||
          (sink_mode == 2 && $urandom_range(0, 2) == 0)) begin
        res_if.ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int gap_len(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [PIDX_W-1:0] pidx,
                           input logic [SYM_W-1:0] sym);
    cmd_if.valid         <= 1'b1;
    cmd_if.func          <= func;
    cmd_if.pattern_index <= pidx;
    cmd_if.symbol        <= sym;
    do @(posedge clk); while (!cmd_if.ready);
    if (tracker.note_item(func, pidx, sym)) items_done++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender until every pending count has come out
  task automatic drain(input int extra);
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_counts.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // leaves valid high so back-to-back writes follow without a gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk); while (!reg_if.ready);
    tracker.write_reg(idx, data);
  endtask

  // registers change only with the block idle
  task automatic setup_phase(input bit do_plen, input logic [CFG_DATA_W-1:0] plen_data,
                             input bit do_rcnt, input logic [CFG_DATA_W-1:0] rcnt_data,
                             input bit do_bogus);
    drain(CFG_SETTLE);
    if (do_bogus)
      write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
    if (do_plen) write_reg(REG_PATTERN_LENGTH, plen_data);
    if (do_rcnt) write_reg(REG_RESULT_COUNT, rcnt_data);
    reg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned len;
    int unsigned n;
    int unsigned rand_base;
    int          r;
    int          text_mode;
    bit          burst;
    bit          do_plen;
    bit          do_rcnt;
    logic [PLEN_W-1:0]     plen_pick;
    logic [CFG_DATA_W-1:0] rcnt_pick;
    logic [SYM_W-1:0]      sym;

    rst_n                = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.func          = FUNC_WRITE;
    cmd_if.pattern_index = '0;
    cmd_if.symbol        = '0;
    reg_if.valid         = 1'b0;
    reg_if.index         = REG_PATTERN_LENGTH;
    reg_if.data          = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Load every pattern entry so no comparison touches an unwritten one
    sink_mode = 1;
    for (int k = 0; k < PAT_DEPTH; k++) begin
      sym = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : SYM_W'(k * 53 + 7);
      send_item(FUNC_WRITE, PIDX_W'(k), sym);
      pause(gap_len(k < 32));
    end

    // Reset registers: one alignment, one symbol
    send_item(FUNC_PUSH, '0, 8'h00);
    send_item(FUNC_PUSH, 6'h3F, 8'hFF);
    send_item(FUNC_UNUSED, 6'h3F, 8'hFF);
    send_item(FUNC_WRITE, 6'd63, 8'hA5);

    // Short window, last flag on the second alignment
    setup_phase(1'b1, 17'd4, 1'b1, 17'd2, 1'b0);
    send_item(FUNC_START, '0, '0);
    for (int k = 0; k < 4; k++) send_item(FUNC_PUSH, '0, tracker.pattern[k]);
    send_item(FUNC_PUSH, '0, 8'h5A);

    // Unknown register index, result_count zero: nothing comes out
    setup_phase(1'b0, '0, 1'b1, 17'd0, 1'b1);
    send_item(FUNC_START, '0, '0);
    for (int k = 0; k < 5; k++) send_item(FUNC_PUSH, '0, tracker.pattern[k % 4]);

    // Pattern rewritten and text restarted in mid-stream
    setup_phase(1'b0, '0, 1'b1, 17'd10, 1'b0);
    send_item(FUNC_START, '0, '0);
    send_item(FUNC_PUSH, '0, tracker.pattern[0]);
    send_item(FUNC_PUSH, '0, tracker.pattern[1]);
    send_item(FUNC_WRITE, 6'd1, 8'h3C);
    for (int k = 0; k < 3; k++) send_item(FUNC_PUSH, '0, tracker.pattern[k + 1]);
    send_item(FUNC_START, '0, '0);
    for (int k = 0; k < 4; k++) send_item(FUNC_PUSH, '0, tracker.pattern[k]);

    // Over-range length (acts as the full row) on an exact copy of the pattern
    setup_phase(1'b1, 17'd127, 1'b1, 17'd65536, 1'b0);
    send_item(FUNC_START, '0, '0);
    for (int k = 0; k < PAT_DEPTH + 2; k++)
      send_item(FUNC_PUSH, '0, tracker.pattern[k % PAT_DEPTH]);

    // Zero length in the low bits (acts as one symbol), over-range result count
    setup_phase(1'b1, 17'h1FF80, 1'b1, 17'h1FFFF, 1'b0);
    send_item(FUNC_START, '0, '0);
    for (int k = 0; k < LONG_PUSHES; k++)
      send_item(FUNC_PUSH, '0, SYM_W'($urandom_range(0, 3)));

    // Random phases
    rand_base = items_done;
    while (items_done - rand_base < RANDOM_ITEMS) begin
      sink_mode = $urandom_range(0, 2);
      burst     = ($urandom_range(0, 3) == 0);
      text_mode = $urandom_range(0, 2);

      case ($urandom_range(0, 9))
        0:       plen_pick = 7'd1;
        1:       plen_pick = 7'd64;
        2:       plen_pick = 7'd0;
        3:       plen_pick = 7'd127;
        4:       plen_pick = PLEN_W'($urandom_range(65, 126));
        5, 6, 7: plen_pick = PLEN_W'($urandom_range(2, 8));
        default: plen_pick = PLEN_W'($urandom_range(9, 64));
      endcase
      case ($urandom_range(0, 9))
        0:       rcnt_pick = 17'd0;
        1:       rcnt_pick = 17'd1;
        2:       rcnt_pick = 17'h1FFFF;
        3:       rcnt_pick = 17'd65536;
        4:       rcnt_pick = CFG_DATA_W'($urandom_range(65537, 131070));
        5, 6, 7: rcnt_pick = CFG_DATA_W'($urandom_range(1, 40));
        default: rcnt_pick = CFG_DATA_W'($urandom_range(41, 300));
      endcase
      do_plen = ($urandom_range(0, 1) == 0);
      do_rcnt = ($urandom_range(0, 1) == 0);
      // upper data bits are don't-care for the length register
      setup_phase(do_plen,
                  {CFG_DATA_W'($urandom_range(0, 1023)) << PLEN_W} | CFG_DATA_W'(plen_pick),
                  do_rcnt, rcnt_pick, $urandom_range(0, 7) == 0);

      if ($urandom_range(0, 7) != 0)
        send_item(FUNC_START, PIDX_W'($urandom), SYM_W'($urandom));

      len = tracker.window_len();
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, len + 8)
                                     : $urandom_range(len, 3 * len + 20);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_item(FUNC_UNUSED, PIDX_W'($urandom), SYM_W'($urandom));
        end else if (r < 9) begin
          send_item(FUNC_WRITE, PIDX_W'($urandom), SYM_W'($urandom));
        end else if (r < 11) begin
          send_item(FUNC_START, PIDX_W'($urandom), SYM_W'($urandom));
        end else begin
          case (text_mode)
            0: sym = SYM_W'($urandom);
            1: sym = ($urandom_range(0, 7) == 0) ? SYM_W'($urandom)
                                                 : tracker.pattern[tracker.text_pos % len];
            default: sym = tracker.pattern[$urandom_range(0, len - 1)];
          endcase
          send_item(FUNC_PUSH, PIDX_W'($urandom), sym);
        end
        if ($urandom_range(0, 49) == 0) drain(0);
        else pause(gap_len(burst));
      end
    end

    drain(TAIL_CYCLES);
    if (tracker.mismatches == 0 && tracker.expected_counts.size() == 0) begin
      $display("sliding_match_count regression: pass");
    end else begin
      $display("sliding_match_count regression: fail");
    end
    $finish;
  end

endmodule
